### src/ring_coverage_pixel_shader_top_macros.svh
// Assertion helpers for the RTL; clk and rst_n are taken from the enclosing module.
`ifndef RING_COVERAGE_PIXEL_SHADER_TOP_MACROS_SVH
`define RING_COVERAGE_PIXEL_SHADER_TOP_MACROS_SVH

// Check a property on every edge outside reset
`define RCPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define RCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/rcps_pkg.sv
package rcps_pkg;

  // Default sizing of the object table and the frame
  localparam int MAX_OBJECTS_DEF  = 16;
  localparam int FRAME_WIDTH_DEF  = 180;
  localparam int FRAME_HEIGHT_DEF = 90;
  localparam int ROW_PITCH_DEF    = 2;

  // Field widths fixed by the word format
  localparam int SLOT_W  = 4;
  localparam int COORD_W = 16;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 8;
  localparam int COUNT_W = 5;
  localparam int GLYPH_W = 6;

  // Arithmetic widths: pixel column in Q.4, differences, squares
  localparam int PX_W  = COL_W + 4;
  localparam int D_W   = 18;
  localparam int SQ_W  = 35;
  localparam int HI_W  = COORD_W + 1;
  localparam int HI2_W = 2 * HI_W;
  localparam int LO2_W = 2 * COORD_W;
  localparam int D2_W  = SQ_W + 1;

  // Item kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Gradient of glyphs, indexed by the clipped count
  localparam int GRADIENT_TOP = 5;
  localparam int GRAD_IDX_W   = $clog2(GRADIENT_TOP + 1);
  localparam logic [GLYPH_W-1:0] GRADIENT [GRADIENT_TOP+1] = '{
    GLYPH_W'(8'h20), GLYPH_W'(8'h2E), GLYPH_W'(8'h3A),
    GLYPH_W'(8'h3B), GLYPH_W'(8'h2B), GLYPH_W'(8'h23)
  };

  typedef struct packed {
    logic                      action;
    logic [SLOT_W-1:0]         slot;
    logic                      object_valid;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [COORD_W-1:0]        radius;
    logic [COORD_W-1:0]        thickness;
    logic [ROW_W-1:0]          pixel_row;
    logic [COL_W-1:0]          pixel_col;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] overlap_count;
    logic [GLYPH_W-1:0] glyph;
  } out_item_t;

  // One table entry as held in memory
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [COORD_W-1:0]        r;
    logic [COORD_W-1:0]        t;
  } geom_t;

  // Tag that travels with each table read through the test pipeline
  typedef struct packed {
    logic live;
    logic obj;
    logic last;
  } tag_t;

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [COUNT_W-1:0] cnt);
    logic [GRAD_IDX_W-1:0] idx;
    idx = (cnt > COUNT_W'(GRADIENT_TOP)) ? GRAD_IDX_W'(GRADIENT_TOP)
                                         : cnt[GRAD_IDX_W-1:0];
    return GRADIENT[idx];
  endfunction

endpackage

### src/rcps_ifs.sv
interface rcps_in_if;
  logic                 valid;
  logic                 ready;
  rcps_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rcps_out_if;
  logic                 valid;
  logic                 ready;
  rcps_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/rcps_ram.sv
module rcps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/rcps_ring_test.sv
module rcps_ring_test #(
  parameter int PY_W = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rcps_pkg::tag_t               tag_in,
  input  rcps_pkg::geom_t              geom,
  input  logic [rcps_pkg::PX_W-1:0]    px,
  input  logic [PY_W-1:0]              py,
  output rcps_pkg::tag_t               tag_out,
  output logic                         hit
);

  rcps_pkg::tag_t                          b_tag_r;
  logic signed [rcps_pkg::D_W-1:0]         dx_r, dy_r;
  logic [rcps_pkg::HI_W-1:0]               hi_r;
  logic [rcps_pkg::COORD_W-1:0]            lo_r;
  logic                                    lo_en_r;

  logic signed [rcps_pkg::D_W-1:0]         dx_nxt, dy_nxt;
  logic signed [2*rcps_pkg::D_W-1:0]       dx_sq, dy_sq;

  rcps_pkg::tag_t                          c_tag_r;
  logic [rcps_pkg::SQ_W-1:0]               dx2_r, dy2_r;
  logic [rcps_pkg::HI2_W-1:0]              hi2_r;
  logic [rcps_pkg::LO2_W-1:0]              lo2_r;
  logic                                    c_lo_en_r;

  logic [rcps_pkg::D2_W-1:0]               d2;

  // Offsets from the centre and the two radius bounds
  assign dx_nxt = $signed({{(rcps_pkg::D_W-rcps_pkg::PX_W){1'b0}}, px})
                  - rcps_pkg::D_W'($signed(geom.cx));
  assign dy_nxt = $signed({{(rcps_pkg::D_W-PY_W){1'b0}}, py})
                  - rcps_pkg::D_W'($signed(geom.cy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tag_r <= '0;
    end else begin
      b_tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    hi_r    <= {1'b0, geom.r} + {1'b0, geom.t};
    lo_r    <= geom.r - geom.t;
    lo_en_r <= geom.r > geom.t;
  end

  // Square the offsets and the bounds
  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_tag_r <= '0;
    end else begin
      c_tag_r <= b_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    dx2_r     <= dx_sq[rcps_pkg::SQ_W-1:0];
    dy2_r     <= dy_sq[rcps_pkg::SQ_W-1:0];
    hi2_r     <= hi_r * hi_r;
    lo2_r     <= lo_r * lo_r;
    c_lo_en_r <= lo_en_r;
  end

  // Compare the squared distance against the ring band
  assign d2  = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign hit = (d2 <= rcps_pkg::D2_W'(hi2_r))
               && (!c_lo_en_r || (d2 >= rcps_pkg::D2_W'(lo2_r)));
  assign tag_out = c_tag_r;

endmodule

### src/ring_coverage_pixel_shader_top.sv
// Channel  Port    Dir  Word
// input    in_ch   in   slot write or pixel query (rcps_pkg::in_item_t)
// result   out_ch  out  overlap count and glyph (rcps_pkg::out_item_t), queries only
//
// A pixel query reads one table entry per cycle from the geometry memory; a pixel outside
// the frame skips the scan.
// The ring test is a two-register pipeline behind the memory's registered read port.
// Reset is synchronous, active low; it clears all slot valid bits and the control state.
// A new word is taken while a result waits in the output register; a finished query
// holds until that register is free.
`include "ring_coverage_pixel_shader_top_macros.svh"

module ring_coverage_pixel_shader_top #(
  parameter int MAX_OBJECTS  = rcps_pkg::MAX_OBJECTS_DEF,
  parameter int FRAME_WIDTH  = rcps_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = rcps_pkg::FRAME_HEIGHT_DEF,
  parameter int ROW_PITCH    = rcps_pkg::ROW_PITCH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rcps_in_if.sink   in_ch,
  rcps_out_if.source out_ch
);

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int PY_MAX = ((1 << rcps_pkg::ROW_W) - 1) * ROW_PITCH * 16;
  localparam int PY_W = $clog2(PY_MAX + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_OBJECTS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [IDX_W-1:0]             k_r, k_nxt;
  logic [MAX_OBJECTS-1:0]       valid_r, valid_nxt;
  logic [rcps_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [rcps_pkg::PX_W-1:0]    px_r;
  logic [PY_W-1:0]              py_r;
  rcps_pkg::tag_t               a_tag_r, a_tag_nxt, tag_out;
  logic                         out_valid_r, out_valid_nxt;
  rcps_pkg::out_item_t          out_data_r;

  logic                         accept, is_query, in_frame, slot_ok, wr_en, issue;
  logic                         hit, load_out;
  logic [IDX_W-1:0]             wr_addr;
  rcps_pkg::geom_t              wr_geom, rd_geom;

  // Decode the accepted word
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_query = (in_ch.data.action == rcps_pkg::ACT_QUERY);
  assign in_frame = (int'(in_ch.data.pixel_row) < FRAME_HEIGHT)
                    && (int'(in_ch.data.pixel_col) < FRAME_WIDTH);
  assign slot_ok  = int'(in_ch.data.slot) < MAX_OBJECTS;
  assign wr_en    = accept && !is_query && slot_ok && in_ch.data.object_valid;
  assign wr_addr  = IDX_W'(in_ch.data.slot);
  assign issue    = (state_r == ST_SCAN);

  assign wr_geom.cx = in_ch.data.center_x;
  assign wr_geom.cy = in_ch.data.center_y;
  assign wr_geom.r  = in_ch.data.radius;
  assign wr_geom.t  = in_ch.data.thickness;

  rcps_ram #(
    .WIDTH($bits(rcps_pkg::geom_t)),
    .DEPTH(MAX_OBJECTS)
  ) u_geom_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_geom),
    .rd_en   (issue),
    .rd_addr (k_r),
    .rd_data (rd_geom)
  );

  rcps_ring_test #(
    .PY_W(PY_W)
  ) u_ring_test (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (a_tag_r),
    .geom    (rd_geom),
    .px      (px_r),
    .py      (py_r),
    .tag_out (tag_out),
    .hit     (hit)
  );

  // Sequence a query and update the slot valid bits
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    a_tag_nxt     = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    load_out      = 1'b0;

    if (tag_out.live && tag_out.obj && hit && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          count_nxt = '0;
          k_nxt     = '0;
          state_nxt = in_frame ? ST_SCAN : ST_HOLD;
        end else if (accept && slot_ok) begin
          valid_nxt[wr_addr] = in_ch.data.object_valid;
        end
      end
      ST_SCAN: begin
        a_tag_nxt.live = 1'b1;
        a_tag_nxt.obj  = valid_r[k_r];
        a_tag_nxt.last = (k_r == LAST_IDX);
        k_nxt          = k_r + 1'b1;
        if (k_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tag_out.live && tag_out.last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      a_tag_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      a_tag_r     <= a_tag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the query point and the result word
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      px_r <= {in_ch.data.pixel_col, 4'b0000};
      py_r <= PY_W'(int'(in_ch.data.pixel_row) * ROW_PITCH * 16);
    end
    if (load_out) begin
      out_data_r.overlap_count <= count_r;
      out_data_r.glyph         <= rcps_pkg::glyph_of(count_r);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `RCPS_ASSERT(a_idle_pipe_empty, (state_r == ST_IDLE) |-> (!a_tag_r.live && !tag_out.live),
               "test pipeline busy while idle")
  `RCPS_ASSERT_NEXT(a_scan_end, (state_r == ST_SCAN) && (k_r == LAST_IDX),
                    (state_r == ST_DRAIN), "scan did not end after the last entry")
  `RCPS_ASSERT_NEXT(a_scan_step, (state_r == ST_SCAN) && (k_r != LAST_IDX),
                    (k_r == $past(k_r) + 1'b1), "scan index skipped an entry")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_RINGS    = rcps_pkg::MAX_OBJECTS_DEF;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES  = 500;
  localparam int PHASE_WORDS  = 430;

  logic clk;
  logic rst_n;

  rcps_in_if  in_ch ();
  rcps_out_if out_ch ();

  ring_coverage_pixel_shader_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the object table
  logic                                ring_live [NUM_RINGS] = '{default: 1'b0};
  logic signed [rcps_pkg::COORD_W-1:0] ring_cx   [NUM_RINGS] = '{default: '0};
  logic signed [rcps_pkg::COORD_W-1:0] ring_cy   [NUM_RINGS] = '{default: '0};
  logic [rcps_pkg::COORD_W-1:0]        ring_rad  [NUM_RINGS] = '{default: '0};
  logic [rcps_pkg::COORD_W-1:0]        ring_thk  [NUM_RINGS] = '{default: '0};

  rcps_pkg::out_item_t pending_shades [$];

  int cycle_cnt = 0;
  int fail_cnt = 0;
  int n_writes = 0;
  int n_queries = 0;
  int n_outside = 0;
  int n_deep = 0;
  int n_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [rcps_pkg::GLYPH_W-1:0] ramp_glyph(input int hits);
    case (hits)
      0:       return 6'h20;  // space
      1:       return 6'h2E;  // dot
      2:       return 6'h3A;  // colon
      3:       return 6'h3B;  // semicolon
      4:       return 6'h2B;  // plus
      default: return 6'h23;  // hash, saturated
    endcase
  endfunction

  // Count the rings whose band |d - r| <= t holds the cell's point, all in squares
  function automatic rcps_pkg::out_item_t shade_pixel(input logic [rcps_pkg::ROW_W-1:0] row,
                                                      input logic [rcps_pkg::COL_W-1:0] col);
    rcps_pkg::out_item_t res;
    longint    px, py, dx, dy, d2, hi, lo;
    logic      covered;
    int        hits;
    hits = 0;
    if (row < rcps_pkg::FRAME_HEIGHT_DEF && col < rcps_pkg::FRAME_WIDTH_DEF) begin
      px = longint'(col) * 16;
      py = longint'(row) * rcps_pkg::ROW_PITCH_DEF * 16;
      for (int k = 0; k < NUM_RINGS; k++) begin
        if (ring_live[k]) begin
          dx = px - longint'(ring_cx[k]);
          dy = py - longint'(ring_cy[k]);
          d2 = dx * dx + dy * dy;
          hi = longint'(ring_rad[k]) + longint'(ring_thk[k]);
          covered = (d2 <= hi * hi);
          // Inner edge only exists while the radius exceeds the thickness
          if (ring_rad[k] > ring_thk[k]) begin
            lo = longint'(ring_rad[k]) - longint'(ring_thk[k]);
            if (d2 < lo * lo) covered = 1'b0;
          end
          if (covered) hits++;
        end
      end
    end
    if (hits > 31) hits = 31;
    res.overlap_count = rcps_pkg::COUNT_W'(hits);
    res.glyph         = ramp_glyph(hits);
    return res;
  endfunction

  task automatic load_slot(input rcps_pkg::in_item_t w);
    if (w.slot < NUM_RINGS) begin
      if (w.object_valid) begin
        ring_live[w.slot] = 1'b1;
        ring_cx[w.slot]   = w.center_x;
        ring_cy[w.slot]   = w.center_y;
        ring_rad[w.slot]  = w.radius;
        ring_thk[w.slot]  = w.thickness;
      end else begin
        // Removal keeps the geometry but drops the valid mark
        ring_live[w.slot] = 1'b0;
      end
    end
  endtask

  task automatic check_shade(input rcps_pkg::out_item_t got);
    rcps_pkg::out_item_t want;
    if (pending_shades.size() == 0) begin
      $error("unexpected result word: overlap_count %0d glyph 'h%h",
             got.overlap_count, got.glyph);
      fail_cnt++;
    end else begin
      want = pending_shades.pop_front();
      if (got.overlap_count !== want.overlap_count) begin
        $error("overlap_count: expected %0d, got %0d", want.overlap_count,
               got.overlap_count);
        fail_cnt++;
      end
      if (got.glyph !== want.glyph) begin
        $error("glyph: expected 'h%h, got 'h%h", want.glyph, got.glyph);
        fail_cnt++;
      end
      n_checked++;
    end
  endtask

  // Watch both channels: mirror writes, predict queries, check result words
  always @(posedge clk) begin
    rcps_pkg::out_item_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (in_ch.data.action == rcps_pkg::ACT_WRITE) begin
        load_slot(in_ch.data);
        n_writes++;
      end else begin
        want = shade_pixel(in_ch.data.pixel_row, in_ch.data.pixel_col);
        pending_shades = {pending_shades, want};
        n_queries++;
        if (in_ch.data.pixel_row >= rcps_pkg::FRAME_HEIGHT_DEF
            || in_ch.data.pixel_col >= rcps_pkg::FRAME_WIDTH_DEF)
          n_outside++;
        if (want.overlap_count >= rcps_pkg::GRADIENT_TOP) n_deep++;
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) check_shade(out_ch.data);
  end

  // Result side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_cnt     <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abandon a hung run
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("ring_coverage_pixel_shader_top test failed");
    $finish;
  end

  function automatic rcps_pkg::in_item_t rand_fields();
    rcps_pkg::in_item_t w;
    w.action       = 1'($urandom_range(0, 1));
    w.slot         = rcps_pkg::SLOT_W'($urandom_range(0, 15));
    w.object_valid = 1'($urandom_range(0, 1));
    w.center_x     = rcps_pkg::COORD_W'($urandom_range(0, 65535));
    w.center_y     = rcps_pkg::COORD_W'($urandom_range(0, 65535));
    w.radius       = rcps_pkg::COORD_W'($urandom_range(0, 65535));
    w.thickness    = rcps_pkg::COORD_W'($urandom_range(0, 65535));
    w.pixel_row    = rcps_pkg::ROW_W'($urandom_range(0, 127));
    w.pixel_col    = rcps_pkg::COL_W'($urandom_range(0, 255));
    return w;
  endfunction

  // Mostly rings placed over the frame, now and then raw geometry
  function automatic rcps_pkg::in_item_t rand_write();
    rcps_pkg::in_item_t w;
    w = rand_fields();
    w.action       = rcps_pkg::ACT_WRITE;
    w.object_valid = ($urandom_range(99) < 78);
    if ($urandom_range(99) < 85) begin
      w.center_x  = rcps_pkg::COORD_W'(int'($urandom_range(0, 3500)) - 300);
      w.center_y  = rcps_pkg::COORD_W'(int'($urandom_range(0, 3400)) - 300);
      w.radius    = rcps_pkg::COORD_W'($urandom_range(0, 1200));
      w.thickness = ($urandom_range(99) < 15) ? rcps_pkg::COORD_W'($urandom_range(0, 1600))
                                              : rcps_pkg::COORD_W'($urandom_range(0, 96));
    end
    return w;
  endfunction

  function automatic rcps_pkg::in_item_t rand_query();
    rcps_pkg::in_item_t w;
    w = rand_fields();
    w.action = rcps_pkg::ACT_QUERY;
    if ($urandom_range(99) < 88) begin
      w.pixel_row = rcps_pkg::ROW_W'($urandom_range(0, rcps_pkg::FRAME_HEIGHT_DEF - 1));
      w.pixel_col = rcps_pkg::COL_W'($urandom_range(0, rcps_pkg::FRAME_WIDTH_DEF - 1));
    end
    return w;
  endfunction

  function automatic rcps_pkg::in_item_t make_write(input int slot, input logic keep,
                                                   input int cx, input int cy,
                                                   input int rad, input int thk);
    rcps_pkg::in_item_t w;
    w              = '0;
    w.action       = rcps_pkg::ACT_WRITE;
    w.slot         = rcps_pkg::SLOT_W'(slot);
    w.object_valid = keep;
    w.center_x     = rcps_pkg::COORD_W'(cx);
    w.center_y     = rcps_pkg::COORD_W'(cy);
    w.radius       = rcps_pkg::COORD_W'(rad);
    w.thickness    = rcps_pkg::COORD_W'(thk);
    return w;
  endfunction

  function automatic rcps_pkg::in_item_t make_query(input int row, input int col);
    rcps_pkg::in_item_t w;
    w           = '0;
    w.action    = rcps_pkg::ACT_QUERY;
    w.pixel_row = rcps_pkg::ROW_W'(row);
    w.pixel_col = rcps_pkg::COL_W'(col);
    return w;
  endfunction

  // Offer one word after a random idle stretch, hold until it is taken
  task automatic send_word(input rcps_pkg::in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop valid and wait for every pending result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(make_query(45, 50));                           // empty table
    send_word(make_write(0, 1'b1, 800, 1440, 160, 16));      // thin ring
    send_word(make_query(45, 60));                           // on the band
    send_word(make_query(45, 50));                           // inside the hole
    send_word(make_write(1, 1'b1, 800, 1440, 32, 48));       // thickness over radius
    send_word(make_query(45, 50));
    send_word(make_write(8, 1'b1, 160, 320, 0, 0));          // single point
    send_word(make_query(10, 10));
    // Discs from the coordinate extremes and the origin that cover the whole frame
    send_word(make_write(2, 1'b1, -32768, -32768, 65535, 65535));
    send_word(make_write(3, 1'b1, 32767, 32767, 65535, 65535));
    send_word(make_write(4, 1'b1, -32768, 32767, 65535, 65535));
    send_word(make_write(5, 1'b1, 32767, -32768, 32767, 65535));
    send_word(make_write(6, 1'b1, 0, 0, 0, 65535));
    send_word(make_write(15, 1'b1, 0, 0, 65535, 65535));
    send_word(make_query(0, 0));                             // saturated glyph
    send_word(make_query(rcps_pkg::FRAME_HEIGHT_DEF - 1, rcps_pkg::FRAME_WIDTH_DEF - 1));
    send_word(make_query(rcps_pkg::FRAME_HEIGHT_DEF, 0));    // below the frame
    send_word(make_query(0, rcps_pkg::FRAME_WIDTH_DEF));     // right of the frame
    send_word(make_query(127, 255));
    send_word(make_write(15, 1'b0, 1, 2, 3, 4));             // removal
    send_word(make_query(rcps_pkg::FRAME_HEIGHT_DEF - 1, rcps_pkg::FRAME_WIDTH_DEF - 1));
    send_word(make_write(6, 1'b0, 0, 0, 0, 0));
    send_word(make_query(70, 100));
    send_word(make_write(2, 1'b0, 0, 0, 0, 0));
    send_word(make_query(70, 100));
    drain_results();
  endtask

  task automatic test_random_phase(input int words, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (words) begin
      if ($urandom_range(99) < 40) send_word(rand_write());
      else send_word(rand_query());
    end
    drain_results();
  endtask

  // Block the result side for a long stretch while queries keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq      <= hold_seq + 1;
    repeat (40) send_word(rand_query());
    drain_results();
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    rst_n        <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(PHASE_WORDS, 0, 0);
    test_random_phase(PHASE_WORDS, 85, 0);
    test_random_phase(PHASE_WORDS, 0, 85);
    test_random_phase(PHASE_WORDS, 17, 17);
    test_backpressure();

    // Catch any stray result word
    in_ch.valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d slot writes and %0d pixel queries (%0d outside the frame).",
             n_writes, n_queries, n_outside);
    $display("Checked %0d results, %0d at the saturated end of the gradient.",
             n_checked, n_deep);
    if (fail_cnt == 0) begin
      $display("ring_coverage_pixel_shader_top test passed");
    end else begin
      $display("ring_coverage_pixel_shader_top test failed");
    end
    $finish;
  end

endmodule
